// ===== rtl/des_feistel_rounds_defines.svh =====
// Assertion macros for the DES Feistel round engine.
// Used by the round cell and the top level; no other dependencies.
`ifndef DES_FEISTEL_ROUNDS_DEFINES_SVH
`define DES_FEISTEL_ROUNDS_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define DES_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DES_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ===== rtl/des_pkg.sv =====
// Package for the DES Feistel round engine: tables, key schedule and round function.
// Used by every module of the block; depends on nothing.
package des_pkg;

   localparam int HalfBits    = 32;
   localparam int KeyHalfBits = 28;
   localparam int SubkeyBits  = 48;
   localparam int MaxRounds   = 16;
   localparam int DefRounds   = 16;
   localparam int CsrAddrBits = 4;

   localparam logic [CsrAddrBits-1:0] CsrAddrC    = 4'h0;
   localparam logic [CsrAddrBits-1:0] CsrAddrD    = 4'h4;
   localparam logic [CsrAddrBits-1:0] CsrAddrMode = 4'h8;

   typedef logic [HalfBits-1:0]    half_type;
   typedef logic [KeyHalfBits-1:0] key_half_type;
   typedef logic [SubkeyBits-1:0]  subkey_type;

   typedef struct packed {
      key_half_type c;
      key_half_type d;
      logic         decrypt;
   } key_type;

   typedef struct packed {
      half_type left;
      half_type right;
   } block_type;

   localparam logic [7:0] TabE [48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
   localparam logic [7:0] TabP [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
   localparam logic [7:0] TabPc2 [48] = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
   localparam logic [1:0] RotEnc [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
   localparam logic [1:0] RotDec [16] = '{0,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

   localparam logic [3:0] SBox [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
        0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
        15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
        3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
        13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
        13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
        1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
        13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
        3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
        14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
        11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
        10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
        4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
        13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
        6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
        1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
        2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   function automatic key_half_type rot_left(key_half_type x, logic [1:0] s);
      key_half_type r;
      case (s)
         2'd1:    r = {x[KeyHalfBits-2:0], x[KeyHalfBits-1]};
         2'd2:    r = {x[KeyHalfBits-3:0], x[KeyHalfBits-1 -: 2]};
         default: r = x;
      endcase
      return r;
   endfunction

   function automatic key_half_type rot_right(key_half_type x, logic [1:0] s);
      key_half_type r;
      case (s)
         2'd1:    r = {x[0], x[KeyHalfBits-1:1]};
         2'd2:    r = {x[1:0], x[KeyHalfBits-1:2]};
         default: r = x;
      endcase
      return r;
   endfunction

   // rotate both halves by the schedule step of round rnd
   function automatic key_type key_step(key_type k, int unsigned rnd);
      key_type r;
      r = k;
      if (k.decrypt) begin
         r.c = rot_right(k.c, RotDec[rnd]);
         r.d = rot_right(k.d, RotDec[rnd]);
      end else begin
         r.c = rot_left(k.c, RotEnc[rnd]);
         r.d = rot_left(k.d, RotEnc[rnd]);
      end
      return r;
   endfunction

   function automatic subkey_type pc2(key_type k);
      logic [55:0] cd;
      subkey_type  r;
      cd = {k.c, k.d};
      for (int i = 0; i < SubkeyBits; i++)
         r[SubkeyBits-1-i] = cd[56 - int'(TabPc2[i])];
      return r;
   endfunction

   function automatic half_type round_f(half_type r, subkey_type k);
      subkey_type x;
      half_type   s;
      half_type   p;
      logic [5:0] six;
      for (int i = 0; i < SubkeyBits; i++)
         x[SubkeyBits-1-i] = r[HalfBits - int'(TabE[i])];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         six = x[SubkeyBits-1-6*i -: 6];
         s[HalfBits-1-4*i -: 4] = SBox[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < HalfBits; i++)
         p[HalfBits-1-i] = s[HalfBits - int'(TabP[i])];
      return p;
   endfunction

endpackage

// ===== rtl/des_if.sv =====
// Valid/ready channel interface carrying one DES block word.
// Depends on des_pkg.
interface des_if import des_pkg::*; ();
   logic      valid;
   logic      ready;
   block_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/des_cell.sv =====
// One Feistel round cell: a pipeline stage holding a block, its key state and valid.
// Depends on des_pkg and des_feistel_rounds_defines.svh.
`include "des_feistel_rounds_defines.svh"
module des_cell import des_pkg::*; #(
   parameter int unsigned RoundIndex = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      prev_valid,
   input  block_type prev_block,
   input  key_type   prev_key,
   output logic      valid,
   output block_type block,
   output key_type   key
);
   logic      valid_ff, valid_in;
   block_type block_ff, block_in;
   key_type   key_ff, key_in;
   key_type   key_rot;

   always_comb begin
      key_rot        = key_step(prev_key, RoundIndex);
      key_in         = key_rot;
      block_in.left  = prev_block.right;
      block_in.right = prev_block.left ^ round_f(prev_block.right, pc2(key_rot));
      valid_in       = advance ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         block_ff <= block_in;
         key_ff   <= key_in;
      end
   end

   assign valid = valid_ff;
   assign block = block_ff;
   assign key   = key_ff;

   `DES_ASSERT_NEXT(a_hold_stall, clock, reset, !advance, $stable(valid_ff),
      "cell valid changed while stalled")
   `DES_ASSERT_NEXT(a_key_hold, clock, reset, !advance, $stable(key_ff),
      "cell key changed while stalled")
   `DES_ASSERT_IMP(a_swap, clock, reset,
      $past(advance) && $past(prev_valid) && !$past(reset),
      block_ff.left == $past(prev_block.right), "halves not swapped")
endmodule

// ===== rtl/des_feistel_rounds.sv =====
// Top level of the DES Feistel round engine: APB key registers, chain of round cells.
// Depends on des_pkg, des_if, des_cell and des_feistel_rounds_defines.svh.
//
//  channel | dir | handshake          | word
//  req     | in  | valid/ready        | left_half, right_half
//  rsp     | out | valid/ready        | left_out, right_out
//  csr     | in  | APB psel/penable   | c_key_half, d_key_half, decrypt_mode
//
// One word enters per cycle while the chain advances; each word is registered once in every round cell.
// The chain advances as a whole whenever the last cell is empty or rsp accepts.
// Reset clears all valid bits and the APB key registers to zero.
`include "des_feistel_rounds_defines.svh"
module des_feistel_rounds import des_pkg::*; #(
   parameter int unsigned ROUND_COUNT = DefRounds
) (
   input  logic                   clock,
   input  logic                   reset,
   des_if.sink                    req,
   des_if.source                  rsp,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CsrAddrBits-1:0] csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   key_type   key_ff, key_in;
   logic      advance;
   logic      cell_valid [ROUND_COUNT+1];
   block_type cell_block [ROUND_COUNT+1];
   key_type   cell_key   [ROUND_COUNT+1];

   assign csr_pready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            CsrAddrC:    key_in.c       = csr_pwdata[KeyHalfBits-1:0];
            CsrAddrD:    key_in.d       = csr_pwdata[KeyHalfBits-1:0];
            CsrAddrMode: key_in.decrypt = csr_pwdata[0];
            default:     key_in         = key_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         CsrAddrC:    csr_prdata = {{(32-KeyHalfBits){1'b0}}, key_ff.c};
         CsrAddrD:    csr_prdata = {{(32-KeyHalfBits){1'b0}}, key_ff.d};
         CsrAddrMode: csr_prdata = {31'd0, key_ff.decrypt};
         default:     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign advance       = !cell_valid[ROUND_COUNT] || rsp.ready;
   assign req.ready     = advance;
   assign cell_valid[0] = req.valid;
   assign cell_block[0] = req.data;
   assign cell_key[0]   = key_ff;

   for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
      des_cell #(.RoundIndex(g)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_valid (cell_valid[g]),
         .prev_block (cell_block[g]),
         .prev_key   (cell_key[g]),
         .valid      (cell_valid[g+1]),
         .block      (cell_block[g+1]),
         .key        (cell_key[g+1])
      );
   end

   assign rsp.valid = cell_valid[ROUND_COUNT];
   assign rsp.data  = cell_block[ROUND_COUNT];

   `DES_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp.valid, req.ready,
      "input stalled with empty output")
   `DES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.data), "stalled result word changed")
   `DES_ASSERT_IMP(a_pready, clock, reset, csr_psel, csr_pready, "pready low")
endmodule
